// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// Antecedent in this cycle implies the consequent at a later cycle.
`define ASSERT_IMPLIES_4(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##4 (cons)) \
		else $error("assertion failed: delayed implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_IMPLIES_4(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Types and fixed constants for the frustum cull classifier.
// ----------------------------------------------------------------------------
package fcc_pkg;

	localparam int NUM_PLANES      = 6;
	localparam int PLANE_SLOT_BITS = 16;
	localparam int PLANE_BITS      = 4 * PLANE_SLOT_BITS;
	localparam int CFG_IDX_W       = 3;
	localparam int RADIUS_BITS     = 15;
	localparam int KIND_W          = 2;
	localparam int VERDICT_W       = 2;

	localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BOX    = 2'd2;

	localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_UNUSED    = 2'd3;

	// Packed plane register: normal x in the low slot, d in the top slot.
	typedef struct packed {
		logic signed [PLANE_SLOT_BITS-1:0] d;
		logic signed [PLANE_SLOT_BITS-1:0] nz;
		logic signed [PLANE_SLOT_BITS-1:0] ny;
		logic signed [PLANE_SLOT_BITS-1:0] nx;
	} plane_t;

endpackage

// ===== hw/rtl/frustum_cull_classifier.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_classifier
// Classifies a point, sphere or box query against six frustum planes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  query    | start & !busy        | kind, pos_x/y/z, max_x/y/z, radius
//  verdict  | done (one cycle)     | verdict
//  config   | cfg_wr_en            | cfg_index, cfg_data
//
//  One query is taken every cycle; busy stays low. A transfer on the query
//  channel passes the input, product, sum and verdict registers, in that
//  order, before its verdict is strobed on done. The 36 parallel
//  16 x COORD_BITS multipliers of the product stage each take one pair per
//  cycle, so nothing holds off. Reset clears the planes and the valid
//  pipeline; payload registers hold no reset. The receiver cannot stall:
//  done is a one-cycle strobe.
//
//  Arithmetic: every distance is d * 2^F + nx*x + ny*y + nz*z, exact.
//  For a box, each axis term takes either the min or the max coordinate,
//  so the smallest and largest corner distances come from picking the
//  smaller or larger of the two products per axis.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_cull_classifier #(
	parameter int COORD_BITS       = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// query channel
	input  logic                                    start,
	output logic                                    busy,
	input  logic [fcc_pkg::KIND_W-1:0]              kind,
	input  logic signed [COORD_BITS-1:0]            pos_x,
	input  logic signed [COORD_BITS-1:0]            pos_y,
	input  logic signed [COORD_BITS-1:0]            pos_z,
	input  logic signed [COORD_BITS-1:0]            max_x,
	input  logic signed [COORD_BITS-1:0]            max_y,
	input  logic signed [COORD_BITS-1:0]            max_z,
	input  logic [fcc_pkg::RADIUS_BITS-1:0]         radius,
	// verdict channel
	output logic                                    done,
	output logic [fcc_pkg::VERDICT_W-1:0]           verdict,
	// configuration port
	input  logic                                    cfg_wr_en,
	input  logic [fcc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [fcc_pkg::PLANE_BITS-1:0]          cfg_data
);
	import fcc_pkg::*;

	localparam int PROD_W = PLANE_SLOT_BITS + COORD_BITS;
	localparam int DSH_W  = PLANE_SLOT_BITS + NORMAL_FRAC_BITS;
	localparam int SUM_W  = ((PROD_W > DSH_W) ? PROD_W : DSH_W) + 3;

	// ------------------------------------------------------------------------
	// Plane registers
	// ------------------------------------------------------------------------
	plane_t plane_q [NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
			plane_q[cfg_index] <= plane_t'(cfg_data);
		end
	end

	// Accept every cycle; nothing inside ever holds off a transfer.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------------
	logic                           valid_s1;
	logic [KIND_W-1:0]              kind_s1;
	logic signed [COORD_BITS-1:0]   lo_s1 [3];
	logic signed [COORD_BITS-1:0]   hi_s1 [3];
	logic [RADIUS_BITS-1:0]         radius_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			lo_s1[0]  <= pos_x;
			lo_s1[1]  <= pos_y;
			lo_s1[2]  <= pos_z;
			hi_s1[0]  <= max_x;
			hi_s1[1]  <= max_y;
			hi_s1[2]  <= max_z;
			radius_s1 <= radius;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2: products of each normal component with min and max coordinate
	// ------------------------------------------------------------------------
	logic                           valid_s2;
	logic [KIND_W-1:0]              kind_s2;
	logic [RADIUS_BITS-1:0]         radius_s2;
	logic signed [PROD_W-1:0]       plo_s2 [NUM_PLANES][3];
	logic signed [PROD_W-1:0]       phi_s2 [NUM_PLANES][3];
	logic signed [PLANE_SLOT_BITS-1:0] norm_c [NUM_PLANES][3];

	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			norm_c[i][0] = plane_q[i].nx;
			norm_c[i][1] = plane_q[i].ny;
			norm_c[i][2] = plane_q[i].nz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_s2   <= kind_s1;
			radius_s2 <= radius_s1;
			for (int i = 0; i < NUM_PLANES; i++) begin
				for (int a = 0; a < 3; a++) begin
					plo_s2[i][a] <= PROD_W'(norm_c[i][a] * lo_s1[a]);
					phi_s2[i][a] <= PROD_W'(norm_c[i][a] * hi_s1[a]);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 3: per-plane sums (centre or minimum corner, smallest, largest)
	// ------------------------------------------------------------------------
	logic                       valid_s3;
	logic [KIND_W-1:0]          kind_s3;
	logic signed [SUM_W-1:0]    rad_s3;
	logic signed [SUM_W-1:0]    dlo_s3  [NUM_PLANES];
	logic signed [SUM_W-1:0]    dmin_s3 [NUM_PLANES];
	logic signed [SUM_W-1:0]    dmax_s3 [NUM_PLANES];

	logic signed [SUM_W-1:0]    dlo_c   [NUM_PLANES];
	logic signed [SUM_W-1:0]    dmin_c  [NUM_PLANES];
	logic signed [SUM_W-1:0]    dmax_c  [NUM_PLANES];
	logic signed [SUM_W-1:0]    rad_c;

	always_comb begin
		logic signed [SUM_W-1:0] base;
		logic signed [SUM_W-1:0] elo;
		logic signed [SUM_W-1:0] ehi;
		for (int i = 0; i < NUM_PLANES; i++) begin
			// d scaled into the product's fixed point
			base = {{(SUM_W-DSH_W){plane_q[i].d[PLANE_SLOT_BITS-1]}},
				plane_q[i].d, {NORMAL_FRAC_BITS{1'b0}}};
			dlo_c[i]  = base;
			dmin_c[i] = base;
			dmax_c[i] = base;
			for (int a = 0; a < 3; a++) begin
				elo = {{(SUM_W-PROD_W){plo_s2[i][a][PROD_W-1]}}, plo_s2[i][a]};
				ehi = {{(SUM_W-PROD_W){phi_s2[i][a][PROD_W-1]}}, phi_s2[i][a]};
				dlo_c[i]  = dlo_c[i] + elo;
				dmin_c[i] = dmin_c[i] + ((elo < ehi) ? elo : ehi);
				dmax_c[i] = dmax_c[i] + ((elo < ehi) ? ehi : elo);
			end
		end
		rad_c = {{(SUM_W-RADIUS_BITS-NORMAL_FRAC_BITS){1'b0}}, radius_s2,
			{NORMAL_FRAC_BITS{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			kind_s3 <= kind_s2;
			rad_s3  <= rad_c;
			for (int i = 0; i < NUM_PLANES; i++) begin
				dlo_s3[i]  <= dlo_c[i];
				dmin_s3[i] <= dmin_c[i];
				dmax_s3[i] <= dmax_c[i];
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4: compare and combine into the verdict register
	// ------------------------------------------------------------------------
	logic [NUM_PLANES-1:0]      pt_out;
	logic [NUM_PLANES-1:0]      sph_out;
	logic [NUM_PLANES-1:0]      sph_near;
	logic [NUM_PLANES-1:0]      box_out;
	logic [NUM_PLANES-1:0]      box_split;
	logic [VERDICT_W-1:0]       verdict_c;

	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			pt_out[i]    = dlo_s3[i] < 0;
			sph_out[i]   = dlo_s3[i] < -rad_s3;
			sph_near[i]  = dlo_s3[i] < rad_s3;
			// every corner out of this plane, or corners on both sides
			box_out[i]   = dmax_s3[i] < 0;
			box_split[i] = dmin_s3[i] < 0;
		end

		case (kind_s3)
			KIND_SPHERE: begin
				if (|sph_out)       verdict_c = VERDICT_OUTSIDE;
				else if (|sph_near) verdict_c = VERDICT_INTERSECT;
				else                verdict_c = VERDICT_INSIDE;
			end
			KIND_BOX: begin
				if (|box_out)        verdict_c = VERDICT_OUTSIDE;
				else if (|box_split) verdict_c = VERDICT_INTERSECT;
				else                 verdict_c = VERDICT_INSIDE;
			end
			// point, and the unused kind code, which behaves as a point
			default: begin
				verdict_c = (|pt_out) ? VERDICT_OUTSIDE : VERDICT_INSIDE;
			end
		endcase
	end

	logic                   done_q;
	logic [VERDICT_W-1:0]   verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			verdict_q <= verdict_c;
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`ASSERT_IMPLIES_4(a_accept_gives_done, clk, arst_n, accept, done)
	`ASSERT_IMPLIES(a_done_has_source, clk, arst_n, done, $past(accept, 4))
	`ASSERT_IMPLIES(a_verdict_code, clk, arst_n, done, verdict != VERDICT_UNUSED)

endmodule
